[src/baro_sensor_compensation_unit_defines.svh]
// ----------------------------------------------------------------------------
// Barometric sensor compensation unit - assertion macros
// Shared property macros for the checker; clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BARO_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_UNIT_DEFINES_SVH

// same-cycle implication
`define BSCU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BSCU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/bscu_pkg.sv]
// ----------------------------------------------------------------------------
// Barometric sensor compensation package
// Payload types, unit request/response structs, register map and scale table.
// ----------------------------------------------------------------------------
package bscu_pkg;

	localparam int RAW_W     = 24;
	localparam int DIVISOR_W = 23;
	localparam int VALUE_W   = 48;
	localparam int CFG_AW    = 5;

	localparam logic MEAS_TEMP = 1'b0;
	localparam logic MEAS_PRES = 1'b1;

	typedef struct packed {
		logic                    command;
		logic signed [RAW_W-1:0] raw_sample;
	} cmd_t;

	typedef struct packed {
		logic                      result_kind;
		logic signed [VALUE_W-1:0] compensated_value;
		logic                      saturated;
	} res_t;

	typedef struct packed {
		logic                    start;
		logic [2:0]              idx;
		logic signed [RAW_W-1:0] raw;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic               clip;
		logic signed [31:0] value;
	} div_rsp_t;

	typedef struct packed {
		logic               start;
		logic               shift;
		logic signed [63:0] x;
		logic signed [63:0] y;
	} mul_req_t;

	typedef struct packed {
		logic               done;
		logic               clip;
		logic signed [63:0] value;
	} mul_rsp_t;

	typedef enum logic [2:0] {
		REG_C0      = 3'd0,
		REG_C1      = 3'd1,
		REG_C00     = 3'd2,
		REG_C10     = 3'd3,
		REG_C01_C11 = 3'd4,
		REG_C20_C21 = 3'd5,
		REG_C30     = 3'd6,
		REG_OSR     = 3'd7
	} reg_idx_t;

	function automatic logic [DIVISOR_W-1:0] scale_divisor(input logic [2:0] idx);
		logic [DIVISOR_W-1:0] d;
		case (idx)
			3'd0:    d = 23'd524288;
			3'd1:    d = 23'd1572864;
			3'd2:    d = 23'd3670016;
			3'd3:    d = 23'd7864320;
			3'd4:    d = 23'd253952;
			3'd5:    d = 23'd516096;
			3'd6:    d = 23'd1040384;
			default: d = 23'd2088960;
		endcase
		return d;
	endfunction

endpackage

[src/bscu_div.sv]
// ----------------------------------------------------------------------------
// Scaling divider
// Restoring bit-serial divide of the raw magnitude by the oversampling scale,
// one quotient bit per cycle, then clamp to signed 32 bits.
// ----------------------------------------------------------------------------
module bscu_div #(
	parameter int SCALED_FRAC_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bscu_pkg::div_req_t  req,
	output bscu_pkg::div_rsp_t  rsp
);
	import bscu_pkg::*;

	localparam int DW = RAW_W + SCALED_FRAC_BITS;
	localparam int CW = $clog2(DW + 1);

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

	dstate_t                state_q;
	logic [DW-1:0]          quo_q;
	logic [DIVISOR_W-1:0]   rem_q;
	logic [DIVISOR_W-1:0]   div_q;
	logic [CW-1:0]          cnt_q;
	logic                   neg_q;
	logic [RAW_W-1:0]       mag;
	logic [DIVISOR_W+1:0]   diff;
	logic                   over;
	logic [31:0]            qlo;

	assign mag  = req.raw[RAW_W-1] ? RAW_W'(-req.raw) : RAW_W'(req.raw);
	assign diff = {1'b0, rem_q, quo_q[DW-1]} - {2'b00, div_q};
	assign qlo  = quo_q[31:0];
	assign over = (|quo_q[DW-1:32]) || (neg_q ? (qlo > 32'h8000_0000) : qlo[31]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= D_IDLE;
			quo_q     <= '0;
			rem_q     <= '0;
			div_q     <= '0;
			cnt_q     <= '0;
			neg_q     <= 1'b0;
			rsp       <= '0;
		end else begin
			rsp.done <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						quo_q   <= DW'(mag) << SCALED_FRAC_BITS;
						rem_q   <= '0;
						div_q   <= scale_divisor(req.idx);
						neg_q   <= req.raw[RAW_W-1];
						cnt_q   <= CW'(DW);
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					if (!diff[DIVISOR_W+1]) begin
						rem_q <= diff[DIVISOR_W-1:0];
					end else begin
						rem_q <= {rem_q[DIVISOR_W-2:0], quo_q[DW-1]};
					end
					quo_q <= {quo_q[DW-2:0], ~diff[DIVISOR_W+1]};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) state_q <= D_FIN;
				end
				D_FIN: begin
					rsp.done <= 1'b1;
					rsp.clip <= over;
					if (over) begin
						rsp.value <= neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
					end else begin
						rsp.value <= neg_q ? $signed(-qlo) : $signed(qlo);
					end
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

endmodule

[src/bscu_mul.sv]
// ----------------------------------------------------------------------------
// Serial multiplier
// Sign-magnitude shift-add multiply, one multiplier bit per cycle, with an
// optional fixed fraction shift and clamp to signed 64 bits.
// ----------------------------------------------------------------------------
module bscu_mul #(
	parameter int SCALED_FRAC_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bscu_pkg::mul_req_t  req,
	output bscu_pkg::mul_rsp_t  rsp
);
	import bscu_pkg::*;

	localparam int STEPS = 64;
	localparam int CW    = $clog2(STEPS + 1);

	typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

	mstate_t        state_q;
	logic [127:0]   prod_q;
	logic [63:0]    a_q;
	logic [63:0]    b_q;
	logic [CW-1:0]  cnt_q;
	logic           neg_q;
	logic           shift_q;
	logic [64:0]    psum;
	logic [127:0]   shifted;
	logic [63:0]    lo;
	logic           over;

	assign psum    = {1'b0, prod_q[127:64]} + (b_q[0] ? {1'b0, a_q} : 65'd0);
	assign shifted = shift_q ? (prod_q >> SCALED_FRAC_BITS) : prod_q;
	assign lo      = shifted[63:0];
	assign over    = (|shifted[127:64]) ||
		(neg_q ? (lo > 64'h8000_0000_0000_0000) : lo[63]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			prod_q  <= '0;
			a_q     <= '0;
			b_q     <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			shift_q <= 1'b0;
			rsp     <= '0;
		end else begin
			rsp.done <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (req.start) begin
						a_q     <= req.x[63] ? 64'(-req.x) : 64'(req.x);
						b_q     <= req.y[63] ? 64'(-req.y) : 64'(req.y);
						neg_q   <= req.x[63] ^ req.y[63];
						shift_q <= req.shift;
						prod_q  <= '0;
						cnt_q   <= CW'(STEPS);
						state_q <= M_RUN;
					end
				end
				M_RUN: begin
					prod_q <= {psum, prod_q[63:1]};
					b_q    <= b_q >> 1;
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) state_q <= M_FIN;
				end
				M_FIN: begin
					rsp.done <= 1'b1;
					rsp.clip <= over;
					if (over) begin
						rsp.value <= neg_q ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
					end else begin
						rsp.value <= neg_q ? $signed(-lo) : $signed(lo);
					end
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

endmodule

[src/baro_sensor_compensation_unit.sv]
// ----------------------------------------------------------------------------
// Barometric sensor compensation unit
// Scales raw temperature/pressure samples and evaluates the calibration
// polynomial with a serial divider and a serial multiply-add sequencer.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake           | Payload
// cmd     | in  | cmd_valid/cmd_ready | cmd_t: command, raw_sample
// res     | out | res_valid/res_ready | res_t: result_kind, compensated_value, saturated
// cfg     | in  | APB, pready tied 1  | 8 coefficient/oversampling registers, up to 32 bits wide
//
// Each item runs the divide, then its multiply-adds, then the output conversion:
// one multiply-add for temperature, six for pressure, all on the single
// bit-serial multiplier.
// Reset clears coefficients, the stored temperature and all control state.
// A waiting result does not block the next accept; the sequencer stalls only
// in its final step until the output register is free.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_unit #(
	parameter int SCALED_FRAC_BITS = 24,
	parameter int RESULT_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  bscu_pkg::cmd_t                cmd,
	output logic                          res_valid,
	input  logic                          res_ready,
	output bscu_pkg::res_t                res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bscu_pkg::CFG_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import bscu_pkg::*;

	localparam int SH_UP = (RESULT_FRAC_BITS > SCALED_FRAC_BITS) ?
		RESULT_FRAC_BITS - SCALED_FRAC_BITS : 0;
	localparam int SH_DN = (SCALED_FRAC_BITS >= RESULT_FRAC_BITS) ?
		SCALED_FRAC_BITS - RESULT_FRAC_BITS : 0;
	localparam logic [71:0] LIM_POS = (72'd1 << (VALUE_W - 1)) - 72'd1;
	localparam logic [71:0] LIM_NEG = 72'd1 << (VALUE_W - 1);

	typedef enum logic [2:0] {S_IDLE, S_SCALE, S_MUL, S_ADD, S_FIN1, S_FIN2} state_t;

	// configuration registers
	logic signed [11:0] c0_q, c1_q;
	logic signed [19:0] c00_q, c10_q;
	logic [31:0]        c01_c11_q, c20_c21_q;
	logic signed [15:0] c30_q;
	logic [5:0]         osr_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c0_q      <= '0;
			c1_q      <= '0;
			c00_q     <= '0;
			c10_q     <= '0;
			c01_c11_q <= '0;
			c20_c21_q <= '0;
			c30_q     <= '0;
			osr_q     <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_C0:      c0_q      <= pwdata[11:0];
				REG_C1:      c1_q      <= pwdata[11:0];
				REG_C00:     c00_q     <= pwdata[19:0];
				REG_C10:     c10_q     <= pwdata[19:0];
				REG_C01_C11: c01_c11_q <= pwdata;
				REG_C20_C21: c20_c21_q <= pwdata;
				REG_C30:     c30_q     <= pwdata[15:0];
				REG_OSR:     osr_q     <= pwdata[5:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_C0:      prdata = {20'd0, c0_q};
			REG_C1:      prdata = {20'd0, c1_q};
			REG_C00:     prdata = {12'd0, c00_q};
			REG_C10:     prdata = {12'd0, c10_q};
			REG_C01_C11: prdata = c01_c11_q;
			REG_C20_C21: prdata = c20_c21_q;
			REG_C30:     prdata = {16'd0, c30_q};
			REG_OSR:     prdata = {26'd0, osr_q};
			default:     prdata = '0;
		endcase
	end

	// sequencer state
	state_t             state_q;
	logic               kind_q;
	logic signed [23:0] raw_q;
	logic signed [31:0] sc_q;
	logic signed [31:0] t_q;
	logic signed [63:0] r_q;
	logic signed [63:0] pp_q;
	logic signed [63:0] mres_q;
	logic [63:0]        mag_q;
	logic               rneg_q;
	logic [2:0]         step_q;
	logic               clip_q;
	logic               div_start_q;
	logic               mul_start_q;
	logic               res_valid_q;
	res_t               res_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	// c0/2 truncated toward zero
	logic signed [12:0] c0_x;
	logic signed [11:0] c0h;
	assign c0_x = 13'(c0_q) + $signed({12'd0, c0_q[11]});
	assign c0h  = 12'(c0_x >>> 1);

	logic signed [63:0] op_x, op_y, addend;
	logic               op_shift;
	logic               last_step;

	always_comb begin
		op_x     = 64'(sc_q);
		op_y     = r_q;
		op_shift = 1'b1;
		addend   = pp_q;
		if (kind_q == MEAS_TEMP) begin
			op_x     = 64'(c1_q);
			op_y     = 64'(t_q);
			op_shift = 1'b0;
			addend   = 64'(c0h) <<< SCALED_FRAC_BITS;
		end else begin
			case (step_q)
				3'd0: begin
					op_y     = 64'(c30_q);
					op_shift = 1'b0;
					addend   = 64'($signed(c20_c21_q[15:0])) <<< SCALED_FRAC_BITS;
				end
				3'd1: addend = 64'(c10_q) <<< SCALED_FRAC_BITS;
				3'd2: addend = 64'(c00_q) <<< SCALED_FRAC_BITS;
				3'd3: begin
					op_y     = 64'($signed(c20_c21_q[31:16]));
					op_shift = 1'b0;
					addend   = 64'($signed(c01_c11_q[31:16])) <<< SCALED_FRAC_BITS;
				end
				3'd4: addend = 64'($signed(c01_c11_q[15:0])) <<< SCALED_FRAC_BITS;
				default: op_x = 64'(t_q);
			endcase
		end
	end

	assign last_step = (kind_q == MEAS_TEMP) || (step_q == 3'd5);

	// saturating accumulate
	logic signed [63:0] sum_raw, sum_sat;
	logic               sum_ovf;
	assign sum_raw = addend + mres_q;
	assign sum_ovf = (addend[63] == mres_q[63]) && (sum_raw[63] != addend[63]);
	assign sum_sat = sum_ovf ? (addend[63] ? 64'sh8000_0000_0000_0000 :
		64'sh7FFF_FFFF_FFFF_FFFF) : sum_raw;

	// conversion to result format
	logic [71:0]        mwide;
	logic               res_over;
	logic [VALUE_W-1:0] mclamp;
	assign mwide    = ({8'd0, mag_q} << SH_UP) >> SH_DN;
	assign res_over = rneg_q ? (mwide > LIM_NEG) : (mwide > LIM_POS);
	assign mclamp   = res_over ? (rneg_q ? VALUE_W'(LIM_NEG) : VALUE_W'(LIM_POS)) :
		mwide[VALUE_W-1:0];

	assign div_req.start = div_start_q;
	assign div_req.idx   = (kind_q == MEAS_PRES) ? osr_q[5:3] : osr_q[2:0];
	assign div_req.raw   = raw_q;

	assign mul_req.start = mul_start_q;
	assign mul_req.shift = op_shift;
	assign mul_req.x     = op_x;
	assign mul_req.y     = op_y;

	bscu_div #(.SCALED_FRAC_BITS(SCALED_FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	bscu_mul #(.SCALED_FRAC_BITS(SCALED_FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= MEAS_TEMP;
			raw_q       <= '0;
			sc_q        <= '0;
			t_q         <= '0;
			r_q         <= '0;
			pp_q        <= '0;
			mres_q      <= '0;
			mag_q       <= '0;
			rneg_q      <= 1'b0;
			step_q      <= '0;
			clip_q      <= 1'b0;
			div_start_q <= 1'b0;
			mul_start_q <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			div_start_q <= 1'b0;
			mul_start_q <= 1'b0;
			if (res_valid_q && res_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						kind_q      <= cmd.command;
						raw_q       <= cmd.raw_sample;
						clip_q      <= 1'b0;
						div_start_q <= 1'b1;
						state_q     <= S_SCALE;
					end
				end
				S_SCALE: begin
					if (div_rsp.done) begin
						sc_q   <= div_rsp.value;
						clip_q <= clip_q | div_rsp.clip;
						if (kind_q == MEAS_TEMP) t_q <= div_rsp.value;
						step_q      <= '0;
						mul_start_q <= 1'b1;
						state_q     <= S_MUL;
					end
				end
				S_MUL: begin
					if (mul_rsp.done) begin
						mres_q  <= mul_rsp.value;
						clip_q  <= clip_q | mul_rsp.clip;
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					r_q    <= sum_sat;
					clip_q <= clip_q | sum_ovf;
					// polynomial in p is parked while the temperature term is built
					if (kind_q == MEAS_PRES && step_q == 3'd2) pp_q <= sum_sat;
					if (last_step) begin
						state_q <= S_FIN1;
					end else begin
						step_q      <= step_q + 3'd1;
						mul_start_q <= 1'b1;
						state_q     <= S_MUL;
					end
				end
				S_FIN1: begin
					mag_q   <= r_q[63] ? 64'(-r_q) : 64'(r_q);
					rneg_q  <= r_q[63];
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					if (!res_valid_q || res_ready) begin
						res_q.result_kind       <= kind_q;
						res_q.compensated_value <= rneg_q ? $signed(-mclamp) : $signed(mclamp);
						res_q.saturated         <= clip_q | res_over;
						res_valid_q             <= 1'b1;
						state_q                 <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[src/bscu_checker.sv]
// ----------------------------------------------------------------------------
// Compensation unit port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "baro_sensor_compensation_unit_defines.svh"

module bscu_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_ready,
	input logic           res_valid,
	input logic           res_ready,
	input bscu_pkg::res_t res,
	input logic           pready
);
	import bscu_pkg::*;

	`BSCU_ASSERT_SAME(a_pready_high, 1'b1, pready, "pready deasserted")
	`BSCU_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res),
		"result changed or dropped while stalled")
	`BSCU_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready,
		"ready still high after an input transfer")
	`BSCU_ASSERT_SAME(a_res_from_work, $rose(res_valid), !$past(cmd_ready),
		"result appeared without work in progress")

endmodule

bind baro_sensor_compensation_unit bscu_checker u_bscu_checker (.*);
